FILE: rtl/core/pwt_pkg.sv
// Shared types, constants and helpers for the four-level page table walker.
// No dependencies; imported by every module of the walker except pwt_ram.
package pwt_pkg;

    // Table memory geometry
    localparam int TABLE_PAGES    = 64;
    localparam int IDX_W          = 9;
    localparam int WORDS_PER_PAGE = 1 << IDX_W;
    localparam int TABLE_WORDS    = TABLE_PAGES * WORDS_PER_PAGE;
    localparam int PAGE_W         = $clog2(TABLE_PAGES);
    localparam int WADDR_W        = PAGE_W + IDX_W;

    // Field widths
    localparam int ENTRY_W   = 64;
    localparam int VA_W      = 48;
    localparam int VPN_W     = VA_W - 12;
    localparam int WA_IN_W   = 15;
    localparam int ROOT_W    = 6;
    localparam int FRAME_W   = 40;
    localparam int FRAME_LSB = 12;
    localparam int SIZE_W    = 2;

    // Entry bits
    localparam int PRESENT_BIT   = 0;
    localparam int PAGE_SIZE_BIT = 7;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_ROOT_PAGE = 1'b0;

    // Item actions
    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    // Page size codes
    localparam logic [SIZE_W-1:0] SIZE_NONE = 2'd0;
    localparam logic [SIZE_W-1:0] SIZE_4K   = 2'd1;
    localparam logic [SIZE_W-1:0] SIZE_2M   = 2'd2;
    localparam logic [SIZE_W-1:0] SIZE_1G   = 2'd3;

    // Walk levels, top table first
    typedef enum logic [1:0] {
        LVL_PML4,
        LVL_PDPT,
        LVL_PD,
        LVL_PT
    } level_t;

    // One request to the table memory port
    typedef struct packed {
        logic               rd_en;
        logic               wr_en;
        logic [WADDR_W-1:0] addr;
        logic [ENTRY_W-1:0] wdata;
    } ram_req_t;

    // Pick the 9-bit table index of a level out of the virtual page number
    function automatic logic [IDX_W-1:0] idx_of(input logic [VPN_W-1:0] vpn, input level_t lvl);
        logic [IDX_W-1:0] idx;
        case (lvl)
            LVL_PML4: idx = vpn[35:27];
            LVL_PDPT: idx = vpn[26:18];
            LVL_PD:   idx = vpn[17:9];
            default:  idx = vpn[8:0];
        endcase
        return idx;
    endfunction

    // True when a page number lies inside table memory
    function automatic logic page_ok(input logic [FRAME_W-1:0] frame);
        return frame < FRAME_W'(TABLE_PAGES);
    endfunction

endpackage

FILE: rtl/core/pwt_ram.sv
// Single-port synchronous RAM holding the page table entries.
// Registered read data; data holds while no read is issued.
module pwt_ram #(
    parameter int ADDR_W = 15,
    parameter int DATA_W = 64
) (
    input  logic              clk,
    input  logic              rd_en,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    // Write and read one word per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wdata;
        end
        if (rd_en)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

FILE: rtl/core/pwt_cfg.sv
// APB-style register file of the walker: holds the root page register.
// Depends on pwt_pkg for the port widths and register index.
module pwt_cfg
    import pwt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic [ROOT_W-1:0]  root_page
);

    logic [ROOT_W-1:0] root_page_reg;
    logic [ROOT_W-1:0] root_page_next;
    logic              reg_index;

    assign reg_index = paddr[2];
    assign pready    = 1'b1;
    assign root_page = root_page_reg;

    // Take the root page on a completed write transaction to its address
    always_comb
    begin
        root_page_next = root_page_reg;
        if (psel && penable && pwrite && reg_index == REG_ROOT_PAGE)
        begin
            root_page_next = pwdata[ROOT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_page_reg <= '0;
        end
        else
        begin
            root_page_reg <= root_page_next;
        end
    end

    // Read back; unknown addresses read as zero
    always_comb
    begin
        prdata = '0;
        if (reg_index == REG_ROOT_PAGE)
        begin
            prdata = PDATA_W'(root_page_reg);
        end
    end

endmodule

FILE: rtl/core/pwt_walk.sv
// Walk sequencer: takes write and lookup transactions, drives the table memory
// port and steps through the levels one read at a time. Depends on pwt_pkg.
module pwt_walk
    import pwt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               action,
    input  logic [WA_IN_W-1:0] word_address,
    input  logic [ENTRY_W-1:0] write_data,
    input  logic [VA_W-1:0]    lookup_address,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [ENTRY_W-1:0] leaf_entry,
    output logic [SIZE_W-1:0]  page_size_code,
    output logic               pointer_out_of_range,
    input  logic [ROOT_W-1:0]  root_page,
    output ram_req_t           ram_req,
    input  logic [ENTRY_W-1:0] ram_rdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DONE
    } state_t;

    state_t             state_reg,  state_next;
    level_t             level_reg,  level_next;
    logic [VPN_W-1:0]   vpn_reg,    vpn_next;
    logic [ENTRY_W-1:0] res_entry_reg, res_entry_next;
    logic [SIZE_W-1:0]  res_code_reg,  res_code_next;
    logic               res_oor_reg,   res_oor_next;
    logic               out_valid_reg, out_valid_next;
    logic [ENTRY_W-1:0] out_entry_reg, out_entry_next;
    logic [SIZE_W-1:0]  out_code_reg,  out_code_next;
    logic               out_oor_reg,   out_oor_next;

    logic               accept;
    logic               out_free;
    logic [FRAME_W-1:0] frame;
    logic [VPN_W-1:0]   in_vpn;
    level_t             level_inc;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign frame     = ram_rdata[FRAME_LSB +: FRAME_W];
    assign in_vpn    = lookup_address[VA_W-1 -: VPN_W];
    assign level_inc = level_t'(level_reg + 2'd1);

    assign out_valid            = out_valid_reg;
    assign leaf_entry           = out_entry_reg;
    assign page_size_code       = out_code_reg;
    assign pointer_out_of_range = out_oor_reg;

    // Next-state and memory request
    always_comb
    begin
        state_next     = state_reg;
        level_next     = level_reg;
        vpn_next       = vpn_reg;
        res_entry_next = res_entry_reg;
        res_code_next  = res_code_reg;
        res_oor_next   = res_oor_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_entry_next = out_entry_reg;
        out_code_next  = out_code_reg;
        out_oor_next   = out_oor_reg;
        ram_req        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (action == ACT_WRITE)
                    begin
                        // Store the entry; drop writes beyond table memory
                        ram_req.wr_en = (32'(word_address) < 32'(TABLE_WORDS));
                        ram_req.addr  = WADDR_W'(word_address);
                        ram_req.wdata = write_data;
                    end
                    else
                    begin
                        vpn_next   = in_vpn;
                        level_next = LVL_PML4;
                        if (page_ok(FRAME_W'(root_page)))
                        begin
                            // Read the top-level entry
                            ram_req.rd_en = 1'b1;
                            ram_req.addr  = {PAGE_W'(root_page), idx_of(in_vpn, LVL_PML4)};
                            state_next    = S_WALK;
                        end
                        else
                        begin
                            res_entry_next = '0;
                            res_code_next  = SIZE_NONE;
                            res_oor_next   = 1'b1;
                            state_next     = S_DONE;
                        end
                    end
                end
            end

            S_WALK:
            begin
                res_entry_next = '0;
                res_code_next  = SIZE_NONE;
                res_oor_next   = 1'b0;
                if (!ram_rdata[PRESENT_BIT])
                begin
                    state_next = S_DONE;
                end
                else if (level_reg == LVL_PDPT && ram_rdata[PAGE_SIZE_BIT])
                begin
                    res_entry_next = ram_rdata;
                    res_code_next  = SIZE_1G;
                    state_next     = S_DONE;
                end
                else if (level_reg == LVL_PD && ram_rdata[PAGE_SIZE_BIT])
                begin
                    res_entry_next = ram_rdata;
                    res_code_next  = SIZE_2M;
                    state_next     = S_DONE;
                end
                else if (level_reg == LVL_PT)
                begin
                    res_entry_next = ram_rdata;
                    res_code_next  = SIZE_4K;
                    state_next     = S_DONE;
                end
                else if (!page_ok(frame))
                begin
                    res_oor_next = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    // Advance to the next-level table
                    ram_req.rd_en = 1'b1;
                    ram_req.addr  = {frame[PAGE_W-1:0], idx_of(vpn_reg, level_inc)};
                    level_next    = level_inc;
                end
            end

            S_DONE:
            begin
                // Hold the result until the output register is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_entry_next = res_entry_reg;
                    out_code_next  = res_code_reg;
                    out_oor_next   = res_oor_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            level_reg     <= LVL_PML4;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            level_reg     <= level_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        vpn_reg       <= vpn_next;
        res_entry_reg <= res_entry_next;
        res_code_reg  <= res_code_next;
        res_oor_reg   <= res_oor_next;
        out_entry_reg <= out_entry_next;
        out_code_reg  <= out_code_next;
        out_oor_reg   <= out_oor_next;
    end

endmodule

FILE: rtl/core/four_level_page_table_walker.sv
// Four-level page table walker over a local single-port table memory of
// TABLE_PAGES pages of 512 64-bit entries. A write transaction stores one entry;
// a lookup reads one entry per level through the memory's registered read port,
// from none (bad root page) or one (miss at the top level) up to four (4 KB
// leaf) before the result register is loaded. Lookups are handled one at a time;
// a new transaction is taken as soon as the previous result has moved into the
// output register. Table entries must be written before any walk reads them.
// The memory needs no clearing after reset. Depends on pwt_pkg, pwt_cfg,
// pwt_walk and pwt_ram.
module four_level_page_table_walker
    import pwt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               action,
    input  logic [WA_IN_W-1:0] word_address,
    input  logic [ENTRY_W-1:0] write_data,
    input  logic [VA_W-1:0]    lookup_address,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [ENTRY_W-1:0] leaf_entry,
    output logic [SIZE_W-1:0]  page_size_code,
    output logic               pointer_out_of_range,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [ROOT_W-1:0]  root_page;
    ram_req_t           ram_req;
    logic [ENTRY_W-1:0] ram_rdata;

    pwt_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .root_page (root_page)
    );

    pwt_walk u_walk (
        .clk                  (clk),
        .rst_n                (rst_n),
        .in_valid             (in_valid),
        .in_ready             (in_ready),
        .action               (action),
        .word_address         (word_address),
        .write_data           (write_data),
        .lookup_address       (lookup_address),
        .out_valid            (out_valid),
        .out_ready            (out_ready),
        .leaf_entry           (leaf_entry),
        .page_size_code       (page_size_code),
        .pointer_out_of_range (pointer_out_of_range),
        .root_page            (root_page),
        .ram_req              (ram_req),
        .ram_rdata            (ram_rdata)
    );

    pwt_ram #(
        .ADDR_W (WADDR_W),
        .DATA_W (ENTRY_W)
    ) u_ram (
        .clk   (clk),
        .rd_en (ram_req.rd_en),
        .wr_en (ram_req.wr_en),
        .addr  (ram_req.addr),
        .wdata (ram_req.wdata),
        .rdata (ram_rdata)
    );

endmodule

FILE: rtl/core/pwt_chk.sv
// Port-level checker for the page table walker, bound to the top level.
// Depends on pwt_pkg for widths and code values.
module pwt_chk
    import pwt_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               action,
    input logic               out_valid,
    input logic               out_ready,
    input logic [ENTRY_W-1:0] leaf_entry,
    input logic [SIZE_W-1:0]  page_size_code,
    input logic               pointer_out_of_range,
    input logic               pready
);

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // A lookup occupies the walker for at least the next cycle
    a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && action == ACT_LOOKUP |=> !in_ready)
        else $error("transaction taken during a walk");

    // A miss carries a zero entry
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && page_size_code == SIZE_NONE |-> leaf_entry == '0)
        else $error("miss with nonzero entry");

    // A leaf is always a present entry
    a_leaf_present: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && page_size_code != SIZE_NONE |->
            leaf_entry[PRESENT_BIT] && !pointer_out_of_range)
        else $error("leaf not present or flagged out of range");

    // The port never waits
    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind four_level_page_table_walker pwt_chk u_chk (.*);

FILE: bench/tb_four_level_page_table_walker.sv
// Self-checking testbench for four_level_page_table_walker: table writes and
// lookups over valid/ready, root page set over the APB-style port.
// Depends on pwt_pkg and the walker RTL only.
module tb_four_level_page_table_walker
    import pwt_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 12;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 140;
    localparam logic [PADDR_W-1:0] ROOT_ADDR  = PADDR_W'(4 * REG_ROOT_PAGE);
    // first address past the register list, writes there must be dropped
    localparam logic [PADDR_W-1:0] SPARE_ADDR = PADDR_W'(4);

    typedef struct packed {
        logic [ENTRY_W-1:0] leaf;
        logic [SIZE_W-1:0]  size_code;
        logic               out_of_range;
    } translation_t;

    // Shadow table memory, root register and outstanding translations
    class translation_checker;
        bit [ENTRY_W-1:0] table_words [TABLE_WORDS];
        bit               written [TABLE_WORDS];
        bit [ROOT_W-1:0]  root_page;
        translation_t     pending_translations [$];
        int               errors;

        // Walk the shadow tables; report the first unwritten word the walk would read
        function void translate(input logic [VA_W-1:0] va, output translation_t res,
                                output int unwritten_word);
            logic [FRAME_W-1:0] table_page;
            logic [ENTRY_W-1:0] e;
            res = '0;
            unwritten_word = -1;
            table_page = FRAME_W'(root_page);
            for (int l = 0; l < 4; l++) begin
                level_t lvl;
                int     slot;
                lvl = level_t'(l);
                if (table_page >= FRAME_W'(TABLE_PAGES)) begin
                    res.out_of_range = 1'b1;
                    return;
                end
                slot = int'(table_page[PAGE_W-1:0]) * WORDS_PER_PAGE
                     + int'(va[VA_W-1-IDX_W*l -: IDX_W]);
                if (!written[slot]) begin
                    unwritten_word = slot;
                    return;
                end
                e = table_words[slot];
                if (!e[PRESENT_BIT])
                    return;
                if (lvl == LVL_PT || (lvl != LVL_PML4 && e[PAGE_SIZE_BIT])) begin
                    res.leaf      = e;
                    res.size_code = (lvl == LVL_PT) ? SIZE_4K :
                                    (lvl == LVL_PD) ? SIZE_2M : SIZE_1G;
                    return;
                end
                table_page = e[FRAME_LSB +: FRAME_W];
            end
        endfunction

        // Apply an accepted input transaction to the shadow state
        function void note_transaction(input logic act, input logic [WA_IN_W-1:0] wa,
                                       input logic [ENTRY_W-1:0] wd,
                                       input logic [VA_W-1:0] va);
            translation_t res;
            int           unwritten_word;
            if (act == ACT_WRITE) begin
                if (int'(wa) < TABLE_WORDS) begin
                    table_words[wa] = wd;
                    written[wa]     = 1'b1;
                end
            end else begin
                translate(va, res, unwritten_word);
                pending_translations.push_back(res);
            end
        endfunction

        // Compare one accepted result with the oldest outstanding translation
        function void check_translation(input logic [ENTRY_W-1:0] leaf,
                                        input logic [SIZE_W-1:0] size_code,
                                        input logic out_of_range);
            translation_t want;
            if (pending_translations.size() == 0) begin
                $error("result with no lookup outstanding: leaf_entry %h", leaf);
                errors++;
                return;
            end
            want = pending_translations.pop_front();
            if (leaf !== want.leaf) begin
                $error("leaf_entry: expected %h, got %h", want.leaf, leaf);
                errors++;
            end
            if (size_code !== want.size_code) begin
                $error("page_size_code: expected %0d, got %0d", want.size_code, size_code);
                errors++;
            end
            if (out_of_range !== want.out_of_range) begin
                $error("pointer_out_of_range: expected %b, got %b",
                       want.out_of_range, out_of_range);
                errors++;
            end
        endfunction

        function void check_root(input logic [PDATA_W-1:0] rdata);
            if (rdata !== PDATA_W'(root_page)) begin
                $error("root_page: expected %h, got %h", PDATA_W'(root_page), rdata);
                errors++;
            end
        endfunction

        function int pending_count();
            return pending_translations.size();
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               action = ACT_WRITE;
    logic [WA_IN_W-1:0] word_address = '0;
    logic [ENTRY_W-1:0] write_data = '0;
    logic [VA_W-1:0]    lookup_address = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [ENTRY_W-1:0] leaf_entry;
    logic [SIZE_W-1:0]  page_size_code;
    logic               pointer_out_of_range;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    translation_checker sb = new();
    int items_sent;
    int burst_left;
    int rx_mode;
    int rx_left;
    int idle_cycles;

    four_level_page_table_walker dut (.*);

    always #2 clk = ~clk;

    // Random value helpers
    function automatic logic [VA_W-1:0] random_va();
        return VA_W'({$urandom, $urandom});
    endfunction

    function automatic logic [IDX_W-1:0] random_index();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            return IDX_W'($urandom_range(0, 3));
        if (pick < 60)
            return '1;
        return IDX_W'($urandom_range(0, WORDS_PER_PAGE - 1));
    endfunction

    function automatic logic [ENTRY_W-1:0] pte(input logic [FRAME_W-1:0] frame,
                                               input logic ps, input logic present);
        logic [ENTRY_W-1:0] e;
        e = '0;
        e[FRAME_LSB +: FRAME_W] = frame;
        e[PAGE_SIZE_BIT]        = ps;
        e[PRESENT_BIT]          = present;
        return e;
    endfunction

    // Mostly present entries that point to a few low pages; some point past memory
    function automatic logic [ENTRY_W-1:0] random_entry();
        logic [ENTRY_W-1:0] e;
        logic [FRAME_W-1:0] frame;
        int unsigned        pick;
        e    = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 50)
            frame = FRAME_W'($urandom_range(0, 7));
        else if (pick < 85)
            frame = FRAME_W'($urandom_range(0, TABLE_PAGES - 1));
        else if (pick < 93)
            frame = FRAME_W'(TABLE_PAGES + $urandom_range(0, 255));
        else
            frame = FRAME_W'({$urandom, $urandom});
        e[FRAME_LSB +: FRAME_W] = frame;
        e[PRESENT_BIT]          = ($urandom_range(0, 99) < 85);
        e[PAGE_SIZE_BIT]        = ($urandom_range(0, 99) < 25);
        return e;
    endfunction

    // Drive one input transaction in bursts with random gaps, hold until accepted
    task automatic send_item(input logic act, input logic [WA_IN_W-1:0] wa,
                             input logic [ENTRY_W-1:0] wd, input logic [VA_W-1:0] va);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 16);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid       <= 1'b1;
        action         <= act;
        word_address   <= wa;
        write_data     <= wd;
        lookup_address <= va;
        do @(posedge clk); while (!in_ready);
        sb.note_transaction(act, wa, wd, va);
        items_sent++;
    endtask

    task automatic put_entry(input int page, input int idx, input logic [ENTRY_W-1:0] e);
        send_item(ACT_WRITE, WA_IN_W'(page * WORDS_PER_PAGE + idx), e, random_va());
    endtask

    // Fill every unwritten entry on the walk path first, then send the lookup
    task automatic lookup_mapped(input logic [VA_W-1:0] va);
        translation_t res;
        int           unwritten_word;
        sb.translate(va, res, unwritten_word);
        while (unwritten_word >= 0) begin
            send_item(ACT_WRITE, WA_IN_W'(unwritten_word), random_entry(), random_va());
            sb.translate(va, res, unwritten_word);
        end
        send_item(ACT_LOOKUP, WA_IN_W'($urandom), {$urandom, $urandom}, va);
    endtask

    // Drop valid and wait until the block has nothing left in flight
    task automatic quiesce();
        in_valid   <= 1'b0;
        burst_left = 0;
        while (sb.pending_count() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One APB transfer: setup, access, then idle with psel low
    task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
                              input logic [PDATA_W-1:0] wdata,
                              output logic [PDATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic read_back_root();
        logic [PDATA_W-1:0] rdata;
        apb_access(1'b0, ROOT_ADDR, '0, rdata);
        sb.check_root(rdata);
    endtask

    task automatic set_root(input logic [ROOT_W-1:0] value);
        logic [PDATA_W-1:0] wdata;
        logic [PDATA_W-1:0] rdata;
        quiesce();
        wdata = $urandom;
        wdata[ROOT_W-1:0] = value;
        apb_access(1'b1, ROOT_ADDR, wdata, rdata);
        sb.root_page = value;
        read_back_root();
    endtask

    function automatic logic [VA_W-1:0] make_va(input int i4, input int i3, input int i2,
                                                input int i1);
        return {IDX_W'(i4), IDX_W'(i3), IDX_W'(i2), IDX_W'(i1), 12'($urandom)};
    endfunction

    // Stimulus: directed walks, then random phases under different root pages
    initial begin
        logic [ROOT_W-1:0]  root_plan [PHASES];
        logic [PDATA_W-1:0] rdata;
        root_plan = '{6'd63, 6'd0, ROOT_W'($urandom), 6'd1, ROOT_W'($urandom), 6'd63};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // top level: not present, pointer past memory
        put_entry(0, 5, pte(7, 1'b1, 1'b0));
        put_entry(0, 6, pte(FRAME_W'(TABLE_PAGES), 1'b0, 1'b1));
        // 1 GB leaves, page-size bit ignored at the top level
        put_entry(0, 0, pte(1, 1'b0, 1'b1));
        put_entry(1, 0, pte(40'hF_FFFF, 1'b1, 1'b1) | 64'hABC0_0000_0000_0000);
        put_entry(0, 1, pte(2, 1'b1, 1'b1));
        put_entry(2, 511, '1);
        // 2 MB leaf, then 4 KB leaves and a miss at the last level
        put_entry(1, 1, pte(3, 1'b0, 1'b1));
        put_entry(3, 0, pte(0, 1'b1, 1'b1) | 64'h8000_0000_0000_0000);
        put_entry(3, 1, pte(4, 1'b0, 1'b1));
        put_entry(4, 0, pte(9, 1'b1, 1'b1));
        put_entry(4, 511, '1);
        put_entry(4, 2, 64'hFFFF_FFFF_FFFF_FFFE);
        put_entry(0, 511, pte(FRAME_W'(TABLE_PAGES - 1), 1'b0, 1'b1));
        put_entry(63, 511, '0);
        lookup_mapped(make_va(5, 0, 0, 0));
        lookup_mapped(make_va(6, 3, 2, 1));
        lookup_mapped('0);
        lookup_mapped(make_va(1, 511, 7, 8));
        lookup_mapped(make_va(0, 1, 0, 9));
        lookup_mapped(make_va(0, 1, 1, 0));
        lookup_mapped(make_va(0, 1, 1, 511));
        lookup_mapped(make_va(0, 1, 1, 2));
        lookup_mapped('1);

        // random phases, each started from idle with a new root page
        for (int p = 0; p < PHASES; p++) begin
            set_root(root_plan[p]);
            if (p == 2) begin
                apb_access(1'b1, SPARE_ADDR, $urandom, rdata);
                read_back_root();
            end
            while (items_sent < 25 + (p + 1) * PHASE_ITEMS) begin
                if ($urandom_range(0, 99) < 15)
                    send_item(ACT_WRITE, WA_IN_W'($urandom_range(0, TABLE_WORDS - 1)),
                              $urandom_range(0, 1) ? random_entry() : {$urandom, $urandom},
                              random_va());
                else
                    lookup_mapped(make_va(random_index(), random_index(),
                                          random_index(), random_index()));
            end
        end

        quiesce();
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Result side: check accepted results, stall on a pattern that changes mode
    always @(posedge clk) begin
        if (out_valid === 1'b1 && out_ready)
            sb.check_translation(leaf_entry, page_size_code, pointer_out_of_range);
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 2);
            rx_left = $urandom_range(16, 96);
        end
        rx_left--;
        case (rx_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= $urandom_range(0, 1);
            default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Watchdog: count cycles with no transaction on any port
    always @(posedge clk) begin
        if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)
            || (psel && penable && pready === 1'b1))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

endmodule
